/* src/weighted_gray_gamma_pixel_unit_assert.svh */
// Assertion macros shared by the pixel unit modules.
// Each macro expects signals named clk and arst_n in the using module.
`ifndef WEIGHTED_GRAY_GAMMA_PIXEL_UNIT_ASSERT_SVH
`define WEIGHTED_GRAY_GAMMA_PIXEL_UNIT_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent.
`define WGGP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define WGGP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

/* src/wggp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wggp_pkg
// Types, register codes and table generators for the gray and gamma pixel unit.
// ----------------------------------------------------------------------------
package wggp_pkg;

	// Pixel request as accepted on the input channel.
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       line_end_in;
		logic       frame_end_in;
	} pixel_t;

	// Result request as delivered on the output channel.
	typedef struct packed {
		logic [7:0] corrected_gray;
		logic       line_end_out;
		logic       frame_end_out;
	} result_t;

	// Configuration register contents.
	typedef struct packed {
		logic [15:0] weight_red;
		logic [15:0] weight_green;
		logic [15:0] weight_blue;
		logic [15:0] gamma_exponent;
	} cfg_t;

	// Control bits that travel alongside the data through every stage.
	typedef struct packed {
		logic valid;
		logic line_end;
		logic frame_end;
	} side_t;

	// Register indexes of the configuration port.
	typedef enum logic [1:0] {
		REG_WEIGHT_RED   = 2'd0,
		REG_WEIGHT_GREEN = 2'd1,
		REG_WEIGHT_BLUE  = 2'd2,
		REG_GAMMA        = 2'd3
	} reg_idx_t;

	localparam int unsigned ADDR_W = 4;
	localparam int unsigned WSUM_W = 18;
	localparam int unsigned SUM_W  = 26;

	// Integer square root, evaluated only while building constant tables.
	function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
		logic [63:0] x;
		logic [63:0] res;
		logic [63:0] bitv;
		x = x_in;
		res = '0;
		bitv = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (x >= res + bitv) begin
				x = x - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// log2(255/g) with fb fraction bits and a three bit integer part.
	function automatic logic [63:0] log_entry(input int g, input int fb);
		logic [63:0] num;
		logic [63:0] den;
		logic [63:0] m;
		logic [63:0] rem;
		logic [63:0] frac;
		int n;
		num = 64'd255 << 30;
		m = '0;
		rem = '0;
		frac = '0;
		n = 0;
		if (g == 0) begin
			return 64'd0;
		end
		for (int i = 1; i <= 8; i++) begin
			if ((g << i) <= 255) begin
				n = i;
			end
		end
		den = 64'(g) << n;
		// Shift and subtract division for the normalized mantissa.
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[62:0], num[i]};
			if (rem >= den) begin
				rem = rem - den;
				m[i] = 1'b1;
			end
		end
		// Squaring yields one fraction bit per pass.
		for (int i = 0; i < fb; i++) begin
			m = (m * m) >> 30;
			frac = frac << 1;
			if (m >= (64'd2 << 30)) begin
				frac = frac | 64'd1;
				m = m >> 1;
			end
		end
		return (64'(n) << fb) | frac;
	endfunction

	// 2^(-2^-k) in Q0.32.
	function automatic logic [63:0] exp_coef(input int k);
		logic [63:0] c;
		c = isqrt64(64'd1 << 63);
		for (int i = 1; i < k; i++) begin
			c = isqrt64(c << 32);
		end
		return c;
	endfunction

endpackage

/* src/wggp_cfg_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wggp_cfg_regs
// APB-style register file holding the color weights and the gamma exponent.
// ----------------------------------------------------------------------------
module wggp_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [wggp_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	output wggp_pkg::cfg_t                cfg
);

	wggp_pkg::cfg_t   cfg_q;
	wggp_pkg::reg_idx_t idx;
	logic             wr_en;

	assign idx    = wggp_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Register writes complete in the access cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.weight_red     <= 16'd1;
			cfg_q.weight_green   <= 16'd1;
			cfg_q.weight_blue    <= 16'd1;
			cfg_q.gamma_exponent <= 16'd4096;
		end else if (wr_en) begin
			unique case (idx)
				wggp_pkg::REG_WEIGHT_RED:   cfg_q.weight_red     <= pwdata[15:0];
				wggp_pkg::REG_WEIGHT_GREEN: cfg_q.weight_green   <= pwdata[15:0];
				wggp_pkg::REG_WEIGHT_BLUE:  cfg_q.weight_blue    <= pwdata[15:0];
				wggp_pkg::REG_GAMMA:        cfg_q.gamma_exponent <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Read data mux.
	always_comb begin
		unique case (idx)
			wggp_pkg::REG_WEIGHT_RED:   prdata = {16'd0, cfg_q.weight_red};
			wggp_pkg::REG_WEIGHT_GREEN: prdata = {16'd0, cfg_q.weight_green};
			wggp_pkg::REG_WEIGHT_BLUE:  prdata = {16'd0, cfg_q.weight_blue};
			wggp_pkg::REG_GAMMA:        prdata = {16'd0, cfg_q.gamma_exponent};
			default:                    prdata = 32'd0;
		endcase
	end

endmodule

/* src/wggp_gray_div.sv */
`timescale 1ns / 1ps
`include "weighted_gray_gamma_pixel_unit_assert.svh"
// ----------------------------------------------------------------------------
// wggp_gray_div
// Weighted sum of the color components divided by the weight sum, in six
// pipeline stages with two quotient bits resolved per divider stage.
// ----------------------------------------------------------------------------
module wggp_gray_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              pix_valid,
	input  wggp_pkg::pixel_t  pix,
	input  wggp_pkg::cfg_t    cfg,
	output logic [7:0]        gray,
	output wggp_pkg::side_t   side_o
);

	localparam int unsigned SW = wggp_pkg::SUM_W;
	localparam int unsigned WW = wggp_pkg::WSUM_W;

	logic [WW-1:0] wsum;

	logic [23:0]   prod_r_s1, prod_g_s1, prod_b_s1;
	logic [SW-1:0] sum_s2;
	logic [SW-1:0] rem_s3, rem_s4, rem_s5;
	logic [7:0]    quo_s3, quo_s4, quo_s5;
	logic [7:0]    gray_s6;
	logic [SW+1:0] step3, step4, step5, step6;

	wggp_pkg::side_t side_s1, side_s2, side_s3, side_s4, side_s5, side_s6;

	// Two restoring division steps for quotient bits hi and hi-1.
	function automatic logic [SW+1:0] div_step2(input logic [SW-1:0] rem_in,
			input logic [WW-1:0] ws, input int hi);
		logic [SW-1:0] r;
		logic [SW-1:0] d;
		logic [1:0]    q;
		r = rem_in;
		q = 2'b00;
		d = SW'(ws) << hi;
		if (r >= d) begin
			r = r - d;
			q[1] = 1'b1;
		end
		d = SW'(ws) << (hi - 1);
		if (r >= d) begin
			r = r - d;
			q[0] = 1'b1;
		end
		return {r, q};
	endfunction

	assign wsum = WW'(cfg.weight_red) + WW'(cfg.weight_green) + WW'(cfg.weight_blue);

	assign step3 = div_step2(sum_s2, wsum, 7);
	assign step4 = div_step2(rem_s3, wsum, 5);
	assign step5 = div_step2(rem_s4, wsum, 3);
	assign step6 = div_step2(rem_s5, wsum, 1);

	// Control bits move one stage on every enabled cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
			side_s2 <= '0;
			side_s3 <= '0;
			side_s4 <= '0;
			side_s5 <= '0;
			side_s6 <= '0;
		end else if (en) begin
			side_s1.valid     <= pix_valid;
			side_s1.line_end  <= pix.line_end_in;
			side_s1.frame_end <= pix.frame_end_in;
			side_s2 <= side_s1;
			side_s3 <= side_s2;
			side_s4 <= side_s3;
			side_s5 <= side_s4;
			side_s6 <= side_s5;
		end
	end

	// Data path: products, sum, then the divider stages.
	always_ff @(posedge clk) begin
		if (en) begin
			prod_r_s1 <= 24'(cfg.weight_red) * 24'(pix.red);
			prod_g_s1 <= 24'(cfg.weight_green) * 24'(pix.green);
			prod_b_s1 <= 24'(cfg.weight_blue) * 24'(pix.blue);
			sum_s2 <= SW'(prod_r_s1) + SW'(prod_g_s1) + SW'(prod_b_s1);
			rem_s3 <= step3[SW+1:2];
			quo_s3 <= {step3[1:0], 6'd0};
			rem_s4 <= step4[SW+1:2];
			quo_s4 <= {quo_s3[7:6], step4[1:0], 4'd0};
			rem_s5 <= step5[SW+1:2];
			quo_s5 <= {quo_s4[7:4], step5[1:0], 2'd0};
			gray_s6 <= (wsum == '0) ? 8'd0 : {quo_s5[7:2], step6[1:0]};
		end
	end

	assign gray   = gray_s6;
	assign side_o = side_s6;

	`WGGP_ASSERT_NEXT(a_zero_weights, en && side_s5.valid && (wsum == '0), gray_s6 == 8'd0, "zero weight sum gave nonzero gray")

endmodule

/* src/wggp_gamma.sv */
`timescale 1ns / 1ps
`include "weighted_gray_gamma_pixel_unit_assert.svh"
// ----------------------------------------------------------------------------
// wggp_gamma
// Gamma correction: log ROM, product with gamma, one stage per log fraction bit
// of the product for the exp2 chain, then the shift and final scaling.
// ----------------------------------------------------------------------------
module wggp_gamma #(
	parameter int unsigned LOG_FRAC_BITS   = 16,
	parameter int unsigned GAMMA_FRAC_BITS = 12
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic [7:0]        gray,
	input  wggp_pkg::side_t   side_i,
	input  wggp_pkg::cfg_t    cfg,
	output wggp_pkg::result_t res,
	output logic              res_valid
);

	localparam int unsigned LF = LOG_FRAC_BITS;
	localparam int unsigned GF = GAMMA_FRAC_BITS;
	localparam int unsigned LW = LF + 3;
	localparam int unsigned PW = LF + 20;

	logic [LW-1:0] log_tab [256];
	logic [31:0]   coef [1:LF];

	logic [LW-1:0] log_s1;
	logic          zero_s1;
	logic [PW-1:0] prod;
	logic [32:0]   t_last;
	logic [41:0]   scaled;
	logic [9:0]    y;

	wggp_pkg::side_t side_s1;

	// Exp chain stage registers, index 0 is written by the product stage.
	logic [32:0]   t_se    [0:LF];
	logic [LF-1:0] frac_se [0:LF];
	logic [2:0]    n_se    [0:LF];
	logic          kill_se [0:LF];
	wggp_pkg::side_t side_se [0:LF];

	wggp_pkg::result_t res_s;
	logic              valid_s;

	// Constant tables.
	for (genvar g = 0; g < 256; g++) begin : g_log_tab
		assign log_tab[g] = LW'(wggp_pkg::log_entry(g, LF));
	end
	for (genvar k = 1; k <= LF; k++) begin : g_coef
		assign coef[k] = 32'(wggp_pkg::exp_coef(k));
	end

	assign prod = PW'(log_s1) * PW'(cfg.gamma_exponent) + (PW'(1) << (GF - 1));

	// Log lookup and product stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1    <= '0;
			side_se[0] <= '0;
		end else if (en) begin
			side_s1    <= side_i;
			side_se[0] <= side_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			log_s1     <= log_tab[gray];
			zero_s1    <= (gray == 8'd0);
			t_se[0]    <= 33'h1_0000_0000;
			frac_se[0] <= prod[GF+LF-1:GF];
			n_se[0]    <= prod[GF+LF+2:GF+LF];
			kill_se[0] <= zero_s1 || (|prod[PW-1:GF+LF+3]);
		end
	end

	// One multiply stage per fraction bit, most significant bit first.
	for (genvar k = 1; k <= LF; k++) begin : g_exp
		logic [64:0] mult;
		assign mult = 65'(t_se[k-1]) * 65'(coef[k]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				side_se[k] <= '0;
			end else if (en) begin
				side_se[k] <= side_se[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				t_se[k]    <= frac_se[k-1][LF-k] ? mult[64:32] : t_se[k-1];
				frac_se[k] <= frac_se[k-1];
				n_se[k]    <= n_se[k-1];
				kill_se[k] <= kill_se[k-1];
			end
		end
	end

	// Integer shift, scale by 255 with rounding slack, clamp.
	assign t_last = t_se[LF] >> n_se[LF];
	assign scaled = 42'(t_last) * 42'(255) + (42'(1) << 27);
	assign y      = scaled[41:32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= 1'b0;
		end else if (en) begin
			valid_s <= side_se[LF].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s.corrected_gray <= kill_se[LF] ? 8'd0 : ((y > 10'd255) ? 8'd255 : y[7:0]);
			res_s.line_end_out   <= side_se[LF].line_end;
			res_s.frame_end_out  <= side_se[LF].frame_end;
		end
	end

	assign res       = res_s;
	assign res_valid = valid_s;

	`WGGP_ASSERT_NEXT(a_kill_zero, en && side_se[LF].valid && kill_se[LF], res_s.corrected_gray == 8'd0, "killed pixel gave nonzero output")
	`WGGP_ASSERT_NEXT(a_hold_out, !en, $stable(res_s) && $stable(valid_s), "output changed while pipeline held")

endmodule

/* src/weighted_gray_gamma_pixel_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_gray_gamma_pixel_unit
// Weighted RGB to gray conversion followed by fixed-point gamma correction.
// ----------------------------------------------------------------------------
// Usage:
// Pixels enter on pixel/pixel_valid and are taken when pixel_stall is low.
// Results leave on result/result_valid and are taken when result_stall is low.
// One pixel is accepted per clock while pixel_stall is low; every pixel
// yields exactly one result and the row and frame end marks travel with it.
// The pipeline stages are, in order: the product and sum registers of the
// weighted sum, four divider stages, log lookup, gamma product, one multiply
// stage per log fraction bit and the final scaling register.
// The whole pipeline advances together; while a result waits under
// result_stall every stage holds and pixel_stall is raised, so nothing is
// lost or repeated. Bubbles travel as invalid stages.
// Reset clears all stage valid bits and loads weights 1,1,1 and gamma 1.0.
// Users write registers on the APB-style port only while idle; not enforced.
// ----------------------------------------------------------------------------
module weighted_gray_gamma_pixel_unit #(
	parameter int unsigned LOG_FRAC_BITS   = 16,
	parameter int unsigned GAMMA_FRAC_BITS = 12
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [wggp_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	input  logic                         pixel_valid,
	output logic                         pixel_stall,
	input  wggp_pkg::pixel_t             pixel,
	output logic                         result_valid,
	input  logic                         result_stall,
	output wggp_pkg::result_t            result
);

	wggp_pkg::cfg_t  cfg;
	wggp_pkg::side_t gray_side;
	logic [7:0]      gray;
	logic            adv;

	// The pipeline moves unless a finished result is being held back.
	assign adv         = !(result_valid && result_stall);
	assign pixel_stall = !adv;

	wggp_cfg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	wggp_gray_div u_gray (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.pix_valid (pixel_valid),
		.pix       (pixel),
		.cfg       (cfg),
		.gray      (gray),
		.side_o    (gray_side)
	);

	wggp_gamma #(
		.LOG_FRAC_BITS   (LOG_FRAC_BITS),
		.GAMMA_FRAC_BITS (GAMMA_FRAC_BITS)
	) u_gamma (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.gray      (gray),
		.side_i    (gray_side),
		.cfg       (cfg),
		.res       (result),
		.res_valid (result_valid)
	);

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the gray and gamma pixel unit against a predictor of its arithmetic.
// Pixels are driven with random gaps, results are taken with random stalls and
// compared field by field, in order, with the predicted results.
// ----------------------------------------------------------------------------
module tb;

	localparam int unsigned LFB = 16;
	localparam int unsigned GFB = 12;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [wggp_pkg::ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        pixel_valid;
	logic        pixel_stall;
	wggp_pkg::pixel_t  pixel;
	logic        result_valid;
	logic        result_stall;
	wggp_pkg::result_t result;

	// Predictor copy of the configuration.
	logic [15:0] w_red, w_green, w_blue, gam;
	wggp_pkg::result_t pending_results[$];
	int          fail_count;
	int          hold_cycles;
	int          gap_cycles;
	bit          stall_enable;

	// Tables built once at the start.
	logic [63:0] log_table[256];
	logic [63:0] exp_table[LFB + 1];

	weighted_gray_gamma_pixel_unit i_dut (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.pready(pready), .pixel_valid(pixel_valid), .pixel_stall(pixel_stall),
		.pixel(pixel), .result_valid(result_valid), .result_stall(result_stall),
		.result(result)
	);

	// Integer square root for the exp factors.
	function automatic logic [63:0] root64(input logic [63:0] x_in);
		logic [63:0] x, res, b;
		x = x_in;
		res = '0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x = x - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// Fills the log and exp tables.
	task automatic build_tables();
		logic [63:0] m, frac, c;
		int n;
		for (int g = 1; g < 256; g++) begin
			n = 0;
			while (n < 8 && ((g << (n + 1)) <= 255)) n++;
			m = (64'd255 << 30) / (64'(g) << n);
			frac = '0;
			for (int i = 0; i < LFB; i++) begin
				m = (m * m) >> 30;
				frac = frac << 1;
				if (m >= (64'd2 << 30)) begin
					frac = frac | 64'd1;
					m = m >> 1;
				end
			end
			log_table[g] = (64'(n) << LFB) | frac;
		end
		c = root64(64'd1 << 63);
		for (int k = 1; k <= LFB; k++) begin
			exp_table[k] = c;
			c = root64(c << 32);
		end
	endtask

	// Gamma corrected gray of one pixel under the current settings.
	function automatic logic [7:0] corrected_gray_of(wggp_pkg::pixel_t px);
		logic [63:0] wsum, sum, gray, p, ip, f, t, y;
		wsum = 64'(w_red) + 64'(w_green) + 64'(w_blue);
		sum = 64'(w_red) * px.red + 64'(w_green) * px.green + 64'(w_blue) * px.blue;
		gray = 0;
		if (wsum != 0) begin
			gray = sum / wsum;
			if (gray > 255) gray = 255;
		end
		if (gray == 0) return 8'd0;
		p = (log_table[gray[7:0]] * 64'(gam) + (64'd1 << (GFB - 1))) >> GFB;
		ip = p >> LFB;
		if (ip >= 8) return 8'd0;
		f = p & ((64'd1 << LFB) - 1);
		t = 64'd1 << 32;
		for (int k = 1; k <= LFB; k++) begin
			if ((f >> (LFB - k)) & 1) t = (t * exp_table[k]) >> 32;
		end
		t = t >> ip;
		y = (64'd255 * t + (64'd1 << 27)) >> 32;
		if (y > 255) y = 255;
		return y[7:0];
	endfunction

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("== FAIL ==");
		$finish;
	end

	// Receiver: random stalls, occasional long ones, plus an optional hold-off.
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			result_stall <= 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else if (gap_cycles > 0) begin
			result_stall <= 1'b1;
			gap_cycles <= gap_cycles - 1;
		end else if (stall_enable) begin
			if ($urandom_range(0, 99) < 2) begin
				result_stall <= 1'b1;
				gap_cycles <= $urandom_range(8, 30);
			end else begin
				result_stall <= ($urandom_range(0, 99) < 25);
			end
		end else begin
			result_stall <= 1'b0;
		end
	end

	// Compares each accepted result with the oldest prediction.
	always @(posedge clk) begin
		wggp_pkg::result_t exp_r;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result %h", result);
				fail_count++;
			end else begin
				exp_r = pending_results.pop_front();
				if (result.corrected_gray !== exp_r.corrected_gray) begin
					$error("corrected_gray expected %0d actual %0d",
						exp_r.corrected_gray, result.corrected_gray);
					fail_count++;
				end
				if (result.line_end_out !== exp_r.line_end_out) begin
					$error("line_end_out expected %0d actual %0d",
						exp_r.line_end_out, result.line_end_out);
					fail_count++;
				end
				if (result.frame_end_out !== exp_r.frame_end_out) begin
					$error("frame_end_out expected %0d actual %0d",
						exp_r.frame_end_out, result.frame_end_out);
					fail_count++;
				end
			end
		end
	end

	// Writes one register through the configuration port.
	task automatic write_reg(wggp_pkg::reg_idx_t idx, logic [15:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= wggp_pkg::ADDR_W'(idx) << 2;
		pwdata <= {16'h0, value};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			wggp_pkg::REG_WEIGHT_RED: w_red = value;
			wggp_pkg::REG_WEIGHT_GREEN: w_green = value;
			wggp_pkg::REG_WEIGHT_BLUE: w_blue = value;
			wggp_pkg::REG_GAMMA: gam = value;
			default: ;
		endcase
	endtask

	task automatic set_config(logic [15:0] r, logic [15:0] g, logic [15:0] b,
		logic [15:0] e);
		write_reg(wggp_pkg::REG_WEIGHT_RED, r);
		write_reg(wggp_pkg::REG_WEIGHT_GREEN, g);
		write_reg(wggp_pkg::REG_WEIGHT_BLUE, b);
		write_reg(wggp_pkg::REG_GAMMA, e);
	endtask

	// Sends one pixel request; gaps are mostly short, a few long.
	// Valid stays high after the request so that the next one can follow at once.
	task automatic send_pixel(wggp_pkg::pixel_t px, bit gaps);
		int gap;
		gap = 0;
		if (gaps) begin
			gap = ($urandom_range(0, 99) < 5) ? $urandom_range(10, 40)
				: (($urandom_range(0, 99) < 30) ? $urandom_range(1, 3) : 0);
		end
		if (gap > 0) begin
			pixel_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pixel_valid <= 1'b1;
		pixel <= px;
		@(posedge clk);
		while (pixel_stall) @(posedge clk);
		pending_results.push_back({corrected_gray_of(px), px.line_end_in,
			px.frame_end_in});
		@(negedge clk);
	endtask

	function automatic wggp_pkg::pixel_t rand_pixel();
		wggp_pkg::pixel_t px;
		px = wggp_pkg::pixel_t'($urandom);
		return px;
	endfunction

	// Ends the pixel stream, waits until every result is back, then idles.
	task automatic drain();
		pixel_valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	// Extremes of the pixel fields and the special cases.
	task automatic test_directed();
		wggp_pkg::pixel_t px;
		set_config(16'd1, 16'd1, 16'd1, 16'd4096);
		send_pixel('0, 0);
		send_pixel('1, 0);
		send_pixel({8'd255, 8'd0, 8'd0, 1'b1, 1'b0}, 0);
		send_pixel({8'd0, 8'd255, 8'd0, 1'b0, 1'b1}, 0);
		send_pixel({8'd0, 8'd0, 8'd255, 1'b1, 1'b1}, 0);
		send_pixel({8'd1, 8'd1, 8'd1, 1'b0, 1'b0}, 0);
		drain();
		// All weights zero gives gray zero.
		set_config(16'd0, 16'd0, 16'd0, 16'd4096);
		send_pixel('1, 0);
		drain();
		// Gamma zero gives full scale for any nonzero gray.
		set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0);
		send_pixel({8'd1, 8'd2, 8'd3, 1'b0, 1'b0}, 0);
		send_pixel('1, 0);
		send_pixel('0, 0);
		drain();
		// Largest gamma drives dark pixels to zero.
		set_config(16'd1, 16'd0, 16'd0, 16'hFFFF);
		px = '0;
		px.red = 8'd1;
		send_pixel(px, 0);
		px.red = 8'd254;
		send_pixel(px, 0);
		px.red = 8'd255;
		send_pixel(px, 0);
		drain();
	endtask

	// Random pixels under one setting.
	task automatic test_random(int count);
		for (int i = 0; i < count; i++) send_pixel(rand_pixel(), 1);
		drain();
	endtask

	// Receiver holds off while the sender keeps offering pixels.
	task automatic test_backpressure();
		set_config(16'd77, 16'd150, 16'd29, 16'd9011);
		@(negedge clk);
		hold_cycles <= 80;
		for (int i = 0; i < 60; i++) send_pixel(rand_pixel(), 0);
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		pixel_valid = 1'b0;
		pixel = '0;
		result_stall = 1'b0;
		hold_cycles = 0;
		gap_cycles = 0;
		stall_enable = 1'b0;
		fail_count = 0;
		w_red = 16'd1;
		w_green = 16'd1;
		w_blue = 16'd1;
		gam = 16'd4096;
		build_tables();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (4) @(negedge clk);
		test_directed();
		stall_enable = 1'b1;
		test_backpressure();
		set_config(16'd1, 16'd1, 16'd1, 16'd4096);
		test_random(250);
		set_config(16'd77, 16'd150, 16'd29, 16'd9011);
		test_random(250);
		set_config(16'hFFFF, 16'd0, 16'hFFFF, 16'd2048);
		test_random(200);
		set_config(16'd0, 16'd0, 16'd0, 16'd4096);
		test_random(50);
		for (int s = 0; s < 8; s++) begin
			set_config(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
			test_random(100);
		end
		if (fail_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

/* filelist.f */
+incdir+src
src/wggp_pkg.sv
src/wggp_cfg_regs.sv
src/wggp_gray_div.sv
src/wggp_gamma.sv
src/weighted_gray_gamma_pixel_unit.sv
bench/tb.sv
